/* rtl/assert_macros.svh */
// Assertion macros used by the top level of the SHA-256 engine.
// Each macro expects a clock named clk and an active-low reset named arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

/* rtl/sha256_pkg.sv */
// Shared types, constants and bit functions of the SHA-256 engine.
// Used by sha256_core and sha256_hash_engine; depends on nothing.
package sha256_pkg;

	typedef logic [31:0] word_t;
	typedef logic [7:0][31:0] chain_t;

	// Input item kinds.
	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_LAST = 2'd1;
	localparam logic [1:0] KIND_END  = 2'd2;

	// Index of the final digest word.
	localparam logic [2:0] WORD_LAST = 3'd7;

	// Padding constants.
	localparam logic [7:0] PAD_MARK   = 8'h80;
	localparam logic [5:0] FILL_LEN   = 6'd56;
	localparam logic [5:0] FILL_FULL  = 6'd63;

	// Initial hash values, word 0 in the low slot.
	localparam chain_t INIT_H = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	// Round constants.
	localparam word_t ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// Control from the byte sequencer to the round unit.
	typedef struct packed {
		logic start;
		logic init;
	} core_ctrl_t;

	// Status from the round unit.
	typedef struct packed {
		logic busy;
		logic round_en;
	} core_stat_t;

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t big_sigma0(input word_t x);
		big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic word_t small_sigma0(input word_t x);
		small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

/* rtl/sha256_hash_engine.sv */
// SHA-256 engine top level: byte intake, padding sequencer and digest output.
// Depends on sha256_pkg, sha256_core and assert_macros.svh.
//
// Usage. Requests arrive on in_valid/in_ready with kind and data_byte: kind 0
// is a message byte, kind 1 a byte that ends the message, kind 2 ends the
// message without a byte, and kind 3 is dropped without effect. in_ready is
// high only while the engine is idle. The 64th byte of a block starts a
// compression of 64 rounds and a final chain add; no new request is taken
// until it is done. The round unit performs one round per cycle.
// At the end of a message the padding bytes (0x80, zeros, the 64-bit bit
// length) are pushed one per cycle, pausing for each of the one or two more
// compressions. Then eight digest words leave on out_valid/out_ready, word 0
// first, last_word marking word 7. While the receiver stalls, the current
// word holds and no new request is taken. After word 7 is taken the chaining
// words return to the initial values and the engine is ready again.
// Reset (arst_n low) loads the initial values and empties the block buffer.
`include "assert_macros.svh"

module sha256_hash_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PAD,
		ST_COMP,
		ST_OUT
	} state_t;

	state_t       state_q;
	logic [511:0] win_q;
	logic [5:0]   fill_q;
	logic [60:0]  len_q;
	logic         first_q;
	logic         len_phase_q;
	logic         pad_mode_q;
	logic         pad_done_q;
	logic [2:0]   out_idx_q;

	logic               accept;
	logic               take_byte;
	logic               push_en;
	logic               pad_is_len;
	logic [7:0]         pad_byte;
	logic [7:0]         push_byte;
	logic [63:0]        len_bits;
	logic [63:0]        len_sh;
	sha256_pkg::word_t  sched_w;
	sha256_pkg::chain_t chain;
	sha256_pkg::core_ctrl_t ctrl;
	sha256_pkg::core_stat_t stat;

	// Intake handshake and byte selection.
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign take_byte = accept && (kind == sha256_pkg::KIND_DATA ||
		kind == sha256_pkg::KIND_LAST);
	assign push_en   = take_byte || (state_q == ST_PAD);

	// Padding byte: the end mark, zeros, then the bit length most significant first.
	assign len_bits   = {len_q, 3'b000};
	assign len_sh     = len_bits << {fill_q[2:0], 3'b000};
	assign pad_is_len = !first_q && (len_phase_q || fill_q == sha256_pkg::FILL_LEN);

	always_comb begin
		if (first_q) begin
			pad_byte = sha256_pkg::PAD_MARK;
		end else if (pad_is_len) begin
			pad_byte = len_sh[63:56];
		end else begin
			pad_byte = 8'h00;
		end
		push_byte = take_byte ? data_byte : pad_byte;
	end

	// Next schedule word from the sliding 16-word window; word 0 is the oldest.
	assign sched_w = sha256_pkg::small_sigma1(win_q[63:32]) + win_q[223:192] +
		sha256_pkg::small_sigma0(win_q[479:448]) + win_q[511:480];

	assign ctrl.start = push_en && (fill_q == sha256_pkg::FILL_FULL);
	assign ctrl.init  = (state_q == ST_OUT) && out_ready && (out_idx_q == sha256_pkg::WORD_LAST);

	sha256_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.w_t    (win_q[511:480]),
		.stat   (stat),
		.chain  (chain)
	);

	// Block window: bytes shift in during intake and padding, schedule words during rounds.
	always_ff @(posedge clk) begin
		if (push_en) begin
			win_q <= {win_q[503:0], push_byte};
		end else if (stat.round_en) begin
			win_q <= {win_q[479:0], sched_w};
		end
	end

	// Sequencer state, counters and output index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			len_q       <= '0;
			first_q     <= 1'b0;
			len_phase_q <= 1'b0;
			pad_mode_q  <= 1'b0;
			pad_done_q  <= 1'b0;
			out_idx_q   <= '0;
		end else begin
			if (push_en) begin
				fill_q <= fill_q + 6'd1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (kind)
							sha256_pkg::KIND_DATA: begin
								len_q      <= len_q + 61'd1;
								pad_mode_q <= 1'b0;
								if (fill_q == sha256_pkg::FILL_FULL) begin
									state_q <= ST_COMP;
								end
							end
							sha256_pkg::KIND_LAST: begin
								len_q      <= len_q + 61'd1;
								pad_mode_q <= 1'b1;
								first_q    <= 1'b1;
								state_q    <= (fill_q == sha256_pkg::FILL_FULL) ?
									ST_COMP : ST_PAD;
							end
							sha256_pkg::KIND_END: begin
								pad_mode_q <= 1'b1;
								first_q    <= 1'b1;
								state_q    <= ST_PAD;
							end
							default: begin
							end
						endcase
					end
				end
				ST_PAD: begin
					first_q <= 1'b0;
					if (!first_q && fill_q == sha256_pkg::FILL_LEN) begin
						len_phase_q <= 1'b1;
					end
					if (fill_q == sha256_pkg::FILL_FULL) begin
						if (pad_is_len) begin
							pad_done_q <= 1'b1;
						end
						state_q <= ST_COMP;
					end
				end
				ST_COMP: begin
					if (!stat.busy) begin
						if (!pad_mode_q) begin
							state_q <= ST_IDLE;
						end else if (pad_done_q) begin
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						if (out_idx_q == sha256_pkg::WORD_LAST) begin
							out_idx_q   <= '0;
							len_q       <= '0;
							len_phase_q <= 1'b0;
							pad_mode_q  <= 1'b0;
							pad_done_q  <= 1'b0;
							state_q     <= ST_IDLE;
						end else begin
							out_idx_q <= out_idx_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Digest output, one chaining word per request.
	assign out_valid   = (state_q == ST_OUT);
	assign digest_word = chain[out_idx_q];
	assign word_index  = out_idx_q;
	assign last_word   = (out_idx_q == sha256_pkg::WORD_LAST);

	// The round unit is quiet whenever new requests can be taken.
	`ASSERT_IMP(a_idle_core, in_ready, !stat.busy)
	// Intake and digest output never overlap.
	`ASSERT_IMP(a_no_overlap, out_valid, !in_ready)
	// Words leave in order.
	`ASSERT_NEXT(a_word_order, out_valid && out_ready && !last_word, word_index == 3'($past(word_index) + 3'd1))
	// After the final word the engine is empty and ready.
	`ASSERT_NEXT(a_ready_after, out_valid && out_ready && last_word, in_ready && fill_q == 6'd0)

endmodule

/* rtl/sha256_core.sv */
// SHA-256 round unit: one compression round per cycle plus the final chain add.
// Depends on sha256_pkg; the message schedule word arrives on w_t each round.
module sha256_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sha256_pkg::core_ctrl_t ctrl,
	input  sha256_pkg::word_t      w_t,
	output sha256_pkg::core_stat_t stat,
	output sha256_pkg::chain_t     chain
);

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_ROUND,
		CS_ADD
	} core_state_t;

	core_state_t        state_q;
	logic [5:0]         rnd_q;
	sha256_pkg::chain_t v_q;
	sha256_pkg::chain_t chain_q;

	sha256_pkg::word_t t1;
	sha256_pkg::word_t t2;
	sha256_pkg::word_t ch;
	sha256_pkg::word_t maj;

	// Round function on the working variables a..h held in v_q[0..7].
	always_comb begin
		ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1  = v_q[7] + sha256_pkg::big_sigma1(v_q[4]) + ch + sha256_pkg::ROUND_K[rnd_q] + w_t;
		t2  = sha256_pkg::big_sigma0(v_q[0]) + maj;
	end

	// Sequencer, working variables and chaining words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			rnd_q   <= '0;
			chain_q <= sha256_pkg::INIT_H;
		end else begin
			unique case (state_q)
				CS_IDLE: begin
					if (ctrl.init) begin
						chain_q <= sha256_pkg::INIT_H;
					end else if (ctrl.start) begin
						v_q     <= chain_q;
						rnd_q   <= '0;
						state_q <= CS_ROUND;
					end
				end
				CS_ROUND: begin
					v_q[7] <= v_q[6];
					v_q[6] <= v_q[5];
					v_q[5] <= v_q[4];
					v_q[4] <= v_q[3] + t1;
					v_q[3] <= v_q[2];
					v_q[2] <= v_q[1];
					v_q[1] <= v_q[0];
					v_q[0] <= t1 + t2;
					rnd_q  <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						state_q <= CS_ADD;
					end
				end
				CS_ADD: begin
					for (int i = 0; i < 8; i++) begin
						chain_q[i] <= chain_q[i] + v_q[i];
					end
					state_q <= CS_IDLE;
				end
				default: begin
					state_q <= CS_IDLE;
				end
			endcase
		end
	end

	assign stat.busy     = (state_q != CS_IDLE);
	assign stat.round_en = (state_q == CS_ROUND);
	assign chain         = chain_q;

endmodule

/* test/sha256_hash_engine_tb.sv */
// Self-checking testbench for sha256_hash_engine: drives byte requests and checks each digest word.
// The expected digests come from a behavioral SHA-256 kept in a small tracker class.
// Depends on sha256_pkg and the sha256_hash_engine RTL.
module sha256_hash_engine_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Kind code that the engine drops without effect.
	localparam logic [1:0] KIND_NOOP = 2'd3;

	localparam int unsigned LIMIT_CYCLES = 500000;
	localparam int unsigned DRAIN_CYCLES = 300;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned MAX_GAP      = 40;

	// One full block, then 56 bytes so that the padding spills into a third block.
	localparam int unsigned LONG_LENGTH = 120;

	localparam bit [31:0] START_WORDS [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam bit [31:0] ROUND_CONST [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef struct {
		bit [31:0] word;
		bit [2:0]  index;
		bit        last;
	} digest_entry_t;

	// Behavioral SHA-256 over the accepted requests plus the queue of digest words owed.
	class digest_tracker;
		digest_entry_t expected_words [$];
		bit [31:0]     chain [8];
		bit [7:0]      blk_bytes [64];
		int unsigned   fill;
		bit [60:0]     byte_count;
		int unsigned   requests;
		int unsigned   messages;
		int unsigned   words_checked;
		int unsigned   mismatches;

		function new();
			restart();
		endfunction

		function void restart();
			chain = START_WORDS;
			fill = 0;
			byte_count = '0;
		endfunction

		function bit [31:0] ror(bit [31:0] x, int unsigned n);
			bit [63:0] twice;
			twice = {x, x} >> n;
			return twice[31:0];
		endfunction

		// One 64-round compression of the full buffer into the chaining words.
		function void compress();
			bit [31:0] w [64];
			bit [31:0] v [8];
			bit [31:0] s0, s1, ch, maj, t1;
			int i;
			for (i = 0; i < 16; i++) begin
				w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
			end
			for (i = 16; i < 64; i++) begin
				s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
				s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
				w[i] = s1 + w[i-7] + s0 + w[i-16];
			end
			v = chain;
			for (i = 0; i < 64; i++) begin
				s1 = ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25);
				ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
				t1 = v[7] + s1 + ch + ROUND_CONST[i] + w[i];
				s0 = ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22);
				maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
				v[7] = v[6];
				v[6] = v[5];
				v[5] = v[4];
				v[4] = v[3] + t1;
				v[3] = v[2];
				v[2] = v[1];
				v[1] = v[0];
				v[0] = t1 + s0 + maj;
			end
			for (i = 0; i < 8; i++) begin
				chain[i] += v[i];
			end
		endfunction

		function void push_byte(bit [7:0] b);
			blk_bytes[fill] = b;
			fill++;
			if (fill == 64) begin
				compress();
				fill = 0;
			end
		endfunction

		// Notes one accepted request; a message end queues the eight digest words.
		function void absorb(logic [1:0] k, logic [7:0] b);
			bit [63:0]     bit_len;
			digest_entry_t e;
			int            i;
			requests++;
			if (k == KIND_NOOP)
				return;
			if (k != sha256_pkg::KIND_END) begin
				push_byte(b);
				byte_count++;
			end
			if (k == sha256_pkg::KIND_DATA)
				return;
			// Padding: the marker byte, zeros up to byte 56, then the bit length.
			bit_len = {byte_count, 3'b000};
			push_byte(8'h80);
			while (fill != 56)
				push_byte(8'h00);
			for (i = 0; i < 8; i++) begin
				push_byte(bit_len[63 - 8*i -: 8]);
			end
			for (i = 0; i < 8; i++) begin
				e.word = chain[i];
				e.index = 3'(i);
				e.last = (i == 7);
				expected_words.push_back(e);
			end
			messages++;
			restart();
		endfunction

		// Compares one accepted digest word with the oldest one owed.
		function void check_word(logic [31:0] w, logic [2:0] idx, logic last);
			digest_entry_t e;
			if (expected_words.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected digest word %h, index %0d, with none pending",
					$time, w, idx);
				return;
			end
			e = expected_words.pop_front();
			words_checked++;
			if (w !== e.word) begin
				mismatches++;
				$display("%0t: digest_word %0d expected %h, got %h", $time, e.index, e.word, w);
			end
			if (idx !== e.index) begin
				mismatches++;
				$display("%0t: word_index expected %0d, got %0d", $time, e.index, idx);
			end
			if (last !== e.last) begin
				mismatches++;
				$display("%0t: last_word at index %0d expected %0b, got %0b",
					$time, e.index, e.last, last);
			end
		endfunction

		function int unsigned pending();
			return expected_words.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  kind = sha256_pkg::KIND_DATA;
	logic [7:0]  data_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	digest_tracker tracker = new();
	int unsigned   send_idle_pct = 0;
	int unsigned   recv_idle_pct = 0;
	bit            hold_request = 1'b0;
	int unsigned   hold_left = 0;
	int unsigned   cycle_count = 0;

	sha256_hash_engine dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: random stalls, or a long hold-off counted here when one is requested.
	always @(negedge clk) begin
		if (hold_request) begin
			hold_left = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Every digest word taken by the receiver is checked.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_word(digest_word, word_index, last_word);
	end

	// Offers one request after a random gap and holds it until it is accepted.
	task automatic send_request(input logic [1:0] k, input logic [7:0] b);
		int unsigned gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct)
			gap++;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		data_byte <= b;
		do
			@(posedge clk);
		while (!in_ready);
		tracker.absorb(k, b);
	endtask

	// A message of random bytes with an occasional dropped request mixed in.
	task automatic send_message(input int unsigned len);
		bit          end_mark;
		int unsigned i;
		end_mark = (len == 0) || ($urandom_range(0, 1) == 1);
		for (i = 0; i < len; i++) begin
			if ($urandom_range(0, 15) == 0)
				send_request(KIND_NOOP, 8'($urandom_range(0, 255)));
			if (i == len - 1 && !end_mark)
				send_request(sha256_pkg::KIND_LAST, 8'($urandom_range(0, 255)));
			else
				send_request(sha256_pkg::KIND_DATA, 8'($urandom_range(0, 255)));
		end
		if (end_mark)
			send_request(sha256_pkg::KIND_END, 8'($urandom_range(0, 255)));
	endtask

	// Short random message lengths, the empty message included.
	function automatic int unsigned pick_length();
		return $urandom_range(0, 6);
	endfunction

	// The sender goes quiet until every digest word owed has been taken.
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	task automatic random_phase(input int unsigned s_pct, input int unsigned r_pct);
		int unsigned first_request;
		int unsigned sent;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		first_request = tracker.requests;
		sent = 0;
		while (sent < 2 || tracker.requests - first_request < 6) begin
			send_message(pick_length());
			sent++;
		end
		wait_drained();
	endtask

	// Run limit.
	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles with %0d digest words pending",
			cycle_count, tracker.pending());
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Directed: empty message, dropped requests, extreme bytes, a short text.
		send_idle_pct = 12;
		recv_idle_pct = 87;
		send_request(KIND_NOOP, 8'hff);
		send_request(sha256_pkg::KIND_END, 8'h00);
		send_request(KIND_NOOP, 8'h00);
		send_request(sha256_pkg::KIND_LAST, 8'h00);
		send_request(sha256_pkg::KIND_LAST, 8'hff);
		send_request(sha256_pkg::KIND_DATA, 8'h61);
		send_request(sha256_pkg::KIND_DATA, 8'h62);
		send_request(sha256_pkg::KIND_LAST, 8'h63);
		send_request(sha256_pkg::KIND_DATA, 8'h80);
		send_request(KIND_NOOP, 8'h55);
		send_request(sha256_pkg::KIND_DATA, 8'h7f);
		send_request(sha256_pkg::KIND_END, 8'hff);
		send_request(sha256_pkg::KIND_DATA, 8'hff);
		send_request(sha256_pkg::KIND_END, 8'haa);
		wait_drained();

		random_phase(12, 87);
		random_phase(87, 12);
		random_phase(0, 0);

		// Long receiver hold-off while the sender keeps offering, so input stalls.
		hold_request = 1'b1;
		send_message(3);
		send_message(2);
		send_message(LONG_LENGTH);
		wait_drained();

		@(negedge clk) in_valid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Summary: %0d requests, %0d messages hashed, %0d digest words checked.",
			tracker.requests, tracker.messages, tracker.words_checked);
		$display("Covered empty, one-byte and block-edge lengths, dropped requests, stalls.");
		if (tracker.mismatches == 0 && tracker.pending() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

/* sha256_hash_engine.f */
+incdir+rtl
rtl/sha256_pkg.sv
rtl/sha256_core.sv
rtl/sha256_hash_engine.sv
test/sha256_hash_engine_tb.sv
